// ===== rtl/core/omw_pkg.sv =====
// Shared types, constants and the sine table function of the omni wheel mixer.
`default_nettype none

package omw_pkg;

  // Default parameter values.
  localparam int QUARTER_TABLE_DEPTH_DEF = 1024;
  localparam int DUTY_BITS_DEF           = 10;

  // Register map: word index of each configuration register.
  localparam int          PADDR_W         = 4;
  localparam logic [1:0]  REG_PWM_LIMIT   = 2'd0;
  localparam logic [1:0]  REG_TURN_GAIN   = 2'd1;
  localparam logic [1:0]  REG_INVERT      = 2'd2;

  // Register reset values.
  localparam logic [9:0]  PWM_LIMIT_RESET = 10'd600;
  localparam logic [11:0] TURN_GAIN_RESET = 12'd333;
  localparam logic        INVERT_RESET    = 1'b0;

  // Fixed-point constants.
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0]     MIX_K_Q16   = 16'd36647;
  localparam int              TAB_W       = 15;
  localparam logic [TAB_W-1:0] TAB_MAX    = 15'd16384;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [9:0]  pwm_limit;
    logic [11:0] turn_gain;
    logic        invert_polarity;
  } cfg_t;

  // Sine of a Q30 angle in Q1.14 through a nested Taylor product; used at elaboration only.
  function automatic logic [TAB_W-1:0] sine_entry(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'(TAB_MAX)) begin
      r = 64'(TAB_MAX);
    end
    return TAB_W'(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/omw_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module omw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, data held while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/omw_regs.sv =====
// APB register file holding the mixer configuration.
`default_nettype none

module omw_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [omw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output omw_pkg::cfg_t                    cfg
);

  logic       wr;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign index  = paddr[3:2];

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_limit       <= omw_pkg::PWM_LIMIT_RESET;
      cfg.turn_gain       <= omw_pkg::TURN_GAIN_RESET;
      cfg.invert_polarity <= omw_pkg::INVERT_RESET;
    end else if (wr) begin
      case (index)
        omw_pkg::REG_PWM_LIMIT: cfg.pwm_limit       <= pwdata[9:0];
        omw_pkg::REG_TURN_GAIN: cfg.turn_gain       <= pwdata[11:0];
        omw_pkg::REG_INVERT:    cfg.invert_polarity <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (index)
      omw_pkg::REG_PWM_LIMIT: prdata = {22'd0, cfg.pwm_limit};
      omw_pkg::REG_TURN_GAIN: prdata = {20'd0, cfg.turn_gain};
      omw_pkg::REG_INVERT:    prdata = {31'd0, cfg.invert_polarity};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/omni_wheel_mixer.sv =====
// Top level of the four-wheel X-configuration omni drive mixer.
//
//   channel   direction  handshake          word
//   input     in         in_valid/in_stall  direction_angle, speed, turn
//   output    out        out_valid/out_stall  4 x (speed, forward, duty)
//   config    in         APB write/read     pwm_limit, turn_gain, invert_polarity
//
// One word per cycle sustained while out_stall is low; a word passes from input to output
// through the table read, sign select, mix multiply, wheel sum, and saturate and limit stages.
// After reset the sine table RAM is loaded with all QUARTER_TABLE_DEPTH + 1 entries,
// during which in_stall is high; configuration writes are taken throughout.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up and the input keeps taking words until every stage holds one.
`default_nettype none

module omni_wheel_mixer #(
  parameter int QUARTER_TABLE_DEPTH = omw_pkg::QUARTER_TABLE_DEPTH_DEF,
  parameter int DUTY_BITS           = omw_pkg::DUTY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [omw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // Input channel.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [11:0]                 direction_angle,
  input  wire logic [9:0]                  speed,
  input  wire logic signed [10:0]          turn,
  // Output channel.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [12:0]               front_left_speed,
  output logic signed [12:0]               front_right_speed,
  output logic signed [12:0]               back_left_speed,
  output logic signed [12:0]               back_right_speed,
  output logic                             front_left_forward,
  output logic                             front_right_forward,
  output logic                             back_left_forward,
  output logic                             back_right_forward,
  output logic [9:0]                       front_left_duty,
  output logic [9:0]                       front_right_duty,
  output logic [9:0]                       back_left_duty,
  output logic [9:0]                       back_right_duty
);

  localparam int TAB_N = QUARTER_TABLE_DEPTH + 1;
  localparam int AW    = $clog2(TAB_N);
  localparam int TW    = omw_pkg::TAB_W;
  localparam int SUM_W = 46;
  localparam logic [9:0] DUTY_CAP =
    (DUTY_BITS >= 10) ? 10'h3FF : 10'((1 << DUTY_BITS) - 1);

  // Wheel lanes.
  localparam int FL = 0;
  localparam int FR = 1;
  localparam int BL = 2;
  localparam int BR = 3;

  omw_pkg::cfg_t cfg;

  // Configuration registers.
  omw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sine table contents, folded to constants at elaboration.
  logic [TW-1:0] qtab [TAB_N];
  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_qtab
    localparam longint unsigned XQ30 =
      (omw_pkg::HALF_PI_Q30 * 64'(gi)) / QUARTER_TABLE_DEPTH;
    assign qtab[gi] = omw_pkg::sine_entry(XQ30);
  end

  // Table load after reset.
  logic          filling;
  logic [AW-1:0] fill_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      filling  <= 1'b1;
      fill_cnt <= '0;
    end else if (filling) begin
      if (fill_cnt == AW'(QUARTER_TABLE_DEPTH)) begin
        filling <= 1'b0;
      end else begin
        fill_cnt <= fill_cnt + AW'(1);
      end
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  logic accept;

  assign en5      = !v5 || !out_stall;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = filling || !en1;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= accept;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: table addresses from the angle; RAM read.
  logic [AW+9:0]  idx_prod;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  cidx;
  logic [TW-1:0]  t_idx1;
  logic [TW-1:0]  t_cidx1;
  logic [1:0]     quad1;
  logic [9:0]     speed1;
  logic signed [10:0] turn1;

  assign idx_prod = (AW+10)'(direction_angle[9:0]) * (AW+10)'(QUARTER_TABLE_DEPTH);
  assign idx      = idx_prod[AW+9:10];
  assign cidx     = AW'(QUARTER_TABLE_DEPTH) - idx;

  omw_ram #(
    .WIDTH (TW),
    .DEPTH (TAB_N)
  ) u_table (
    .clk     (clk),
    .we      (filling),
    .waddr   (fill_cnt),
    .wdata   (qtab[fill_cnt]),
    .re      (accept),
    .raddr_a (idx),
    .raddr_b (cidx),
    .rdata_a (t_idx1),
    .rdata_b (t_cidx1)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      quad1  <= direction_angle[11:10];
      speed1 <= speed;
      turn1  <= turn;
    end
  end

  // Stage 2: quadrant signs, x/y sums, speed scale and turn term.
  logic [TW-1:0]      sin_mag, cos_mag;
  logic signed [16:0] sx, cy;
  logic signed [23:0] turn_x, gain_x;
  logic signed [16:0] sum_p2, sum_m2;
  logic [25:0]        speed_k2;
  logic signed [23:0] ang2;

  always_comb begin
    sin_mag = quad1[0] ? t_cidx1 : t_idx1;
    cos_mag = quad1[0] ? t_idx1 : t_cidx1;
    sx      = quad1[1] ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});
    cy      = (quad1[1] ^ quad1[0]) ? -$signed({2'b00, cos_mag})
                                    : $signed({2'b00, cos_mag});
    turn_x  = 24'(turn1);
    gain_x  = $signed({12'd0, cfg.turn_gain});
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sum_p2   <= sx + cy;
      sum_m2   <= cy - sx;
      speed_k2 <= 26'(speed1) * 26'(omw_pkg::MIX_K_Q16);
      ang2     <= turn_x * gain_x;
    end
  end

  // Stage 3: translational products at Q30.
  logic signed [43:0] sk_x, sp_x, sm_x;
  logic signed [43:0] trans_p3, trans_m3;
  logic signed [23:0] ang3;

  always_comb begin
    sk_x = $signed({18'd0, speed_k2});
    sp_x = 44'(sum_p2);
    sm_x = 44'(sum_m2);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      trans_p3 <= sk_x * sp_x;
      trans_m3 <= sk_x * sm_x;
      ang3     <= ang2;
    end
  end

  // Stage 4: wheel sums with the turn term scaled to Q30.
  logic signed [SUM_W-1:0] ang_q, tp_x, tm_x;
  logic signed [SUM_W-1:0] sum4 [4];

  always_comb begin
    ang_q = $signed({ang3, 22'd0});
    tp_x  = SUM_W'(trans_p3);
    tm_x  = SUM_W'(trans_m3);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sum4[FL] <= tp_x + ang_q;
      sum4[FR] <= tm_x - ang_q;
      sum4[BL] <= tm_x + ang_q;
      sum4[BR] <= tp_x - ang_q;
    end
  end

  // Stage 5: truncate toward zero, saturate, direction bit and duty limit.
  logic [9:0]         lim;
  logic signed [16:0] quo  [4];
  logic signed [12:0] sat  [4];
  logic [11:0]        mag  [4];
  logic signed [12:0] speed_q [4];
  logic               fwd_q   [4];
  logic [9:0]         duty_q  [4];
  logic [9:0]         duty_n  [4];
  logic               fwd_n   [4];

  always_comb begin
    lim = (cfg.pwm_limit > DUTY_CAP) ? DUTY_CAP : cfg.pwm_limit;
    for (int w = 0; w < 4; w++) begin
      quo[w] = {sum4[w][SUM_W-1], sum4[w][SUM_W-1:30]}
             + {16'd0, sum4[w][SUM_W-1] & (|sum4[w][29:0])};
      if (quo[w] > 17'sd4095) begin
        sat[w] = 13'sd4095;
      end else if (quo[w] < -17'sd4095) begin
        sat[w] = -13'sd4095;
      end else begin
        sat[w] = quo[w][12:0];
      end
      mag[w]    = sat[w][12] ? 12'(-sat[w]) : sat[w][11:0];
      duty_n[w] = (mag[w] > {2'b00, lim}) ? lim : mag[w][9:0];
      fwd_n[w]  = (sat[w] > 13'sd0) ^ cfg.invert_polarity;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int w = 0; w < 4; w++) begin
        speed_q[w] <= sat[w];
        fwd_q[w]   <= fwd_n[w];
        duty_q[w]  <= duty_n[w];
      end
    end
  end

  // Output word.
  assign out_valid           = v5;
  assign front_left_speed    = speed_q[FL];
  assign front_right_speed   = speed_q[FR];
  assign back_left_speed     = speed_q[BL];
  assign back_right_speed    = speed_q[BR];
  assign front_left_forward  = fwd_q[FL];
  assign front_right_forward = fwd_q[FR];
  assign back_left_forward   = fwd_q[BL];
  assign back_right_forward  = fwd_q[BR];
  assign front_left_duty     = duty_q[FL];
  assign front_right_duty    = duty_q[FR];
  assign back_left_duty      = duty_q[BL];
  assign back_right_duty     = duty_q[BR];

endmodule

`default_nettype wire

// ===== rtl/core/omw_checker.sv =====
// Port-level checker for the omni wheel mixer, bound to the top level.
`default_nettype none

module omw_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic                        pready,
  input wire logic [omw_pkg::PADDR_W-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic signed [12:0]          front_left_speed,
  input wire logic signed [12:0]          front_right_speed,
  input wire logic signed [12:0]          back_left_speed,
  input wire logic signed [12:0]          back_right_speed,
  input wire logic                        front_left_forward,
  input wire logic                        front_right_forward,
  input wire logic                        back_left_forward,
  input wire logic                        back_right_forward,
  input wire logic [9:0]                  front_left_duty,
  input wire logic [9:0]                  front_right_duty,
  input wire logic [9:0]                  back_left_duty,
  input wire logic [9:0]                  back_right_duty
);

  logic [9:0] limit_seen;
  logic       invert_seen;
  logic       wr;

  assign wr = psel && penable && pwrite && pready;

  // Track the limit and polarity as written over the bus.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_seen  <= omw_pkg::PWM_LIMIT_RESET;
      invert_seen <= omw_pkg::INVERT_RESET;
    end else if (wr) begin
      if (paddr[3:2] == omw_pkg::REG_PWM_LIMIT) begin
        limit_seen <= pwdata[9:0];
      end
      if (paddr[3:2] == omw_pkg::REG_INVERT) begin
        invert_seen <= pwdata[0];
      end
    end
  end

  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  // No duty exceeds the programmed limit.
  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> front_left_duty <= limit_seen && front_right_duty <= limit_seen &&
                  back_left_duty <= limit_seen && back_right_duty <= limit_seen)
    else $error("duty above pwm limit");

  // Forward bits follow the sign of the wheel speed and the polarity setting.
  a_forward: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> front_left_forward == ((front_left_speed > 13'sd0) ^ invert_seen) &&
                  front_right_forward == ((front_right_speed > 13'sd0) ^ invert_seen) &&
                  back_left_forward == ((back_left_speed > 13'sd0) ^ invert_seen) &&
                  back_right_forward == ((back_right_speed > 13'sd0) ^ invert_seen))
    else $error("forward bit disagrees with wheel speed");

  // A stopped wheel gets no drive.
  a_zero_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (front_left_speed != 13'sd0 || front_left_duty == 10'd0) &&
                  (front_right_speed != 13'sd0 || front_right_duty == 10'd0) &&
                  (back_left_speed != 13'sd0 || back_left_duty == 10'd0) &&
                  (back_right_speed != 13'sd0 || back_right_duty == 10'd0))
    else $error("duty nonzero on a stopped wheel");

  // A stalled output word stays valid, with its front-left speed and back-right duty stable.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(front_left_speed) &&
                               $stable(back_right_duty))
    else $error("stalled output word changed");

endmodule

bind omni_wheel_mixer omw_checker u_omw_checker (.*);

`default_nettype wire

// ===== tb/omw_mix_check_pkg.sv =====
// Expected-word model and checker for the omni wheel mixer testbench.
`timescale 1ns / 100ps

package omw_mix_check_pkg;

  // One output word: speed, forward bit and duty for each of the four wheels.
  typedef struct {
    logic signed [12:0] wspeed [4];
    logic               fwd    [4];
    logic [9:0]         duty   [4];
  } wheel_word_t;

  class wheel_mix_checker;
    localparam int     TAB_DEPTH = omw_pkg::QUARTER_TABLE_DEPTH_DEF;
    localparam longint Q30       = 64'sd1073741824;
    localparam longint WHEEL_MAX = 64'sd4095;

    bit [9:0]    pwm_limit;
    bit [11:0]   turn_gain;
    bit          invert_polarity;
    longint      sine_tab [TAB_DEPTH+1];
    string       wheel_name [4];
    wheel_word_t pending_wheels [$];
    int          mismatches;

    function new();
      for (int i = 0; i <= TAB_DEPTH; i++) begin
        sine_tab[i] = sine_q14(i);
      end
      wheel_name = '{"front_left", "front_right", "back_left", "back_right"};
      pwm_limit       = omw_pkg::PWM_LIMIT_RESET;
      turn_gain       = omw_pkg::TURN_GAIN_RESET;
      invert_polarity = omw_pkg::INVERT_RESET;
      mismatches      = 0;
    endfunction

    // Quarter-wave sine in Q1.14 from a nested Taylor product carried in Q30.
    function longint sine_q14(int i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned r;
      x  = (omw_pkg::HALF_PI_Q30 * longint'(i)) / TAB_DEPTH;
      x2 = (x * x) >> 30;
      t  = omw_pkg::Q30_ONE - x2 / 110;
      t  = omw_pkg::Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = omw_pkg::Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = omw_pkg::Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = omw_pkg::Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s + 64'd32768) >> 16;
      if (r > omw_pkg::TAB_MAX) begin
        r = omw_pkg::TAB_MAX;
      end
      return longint'(r);
    endfunction

    // Mirror of a register write; bits above each register's width are dropped.
    function void write_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        omw_pkg::REG_PWM_LIMIT: pwm_limit       = value[9:0];
        omw_pkg::REG_TURN_GAIN: turn_gain       = value[11:0];
        omw_pkg::REG_INVERT:    invert_polarity = value[0];
        default: ;
      endcase
    endfunction

    // Sum of the two Q30 terms, truncated toward zero and saturated.
    function longint wheel_speed(longint trans_q30, longint turn_q30);
      longint v;
      v = (trans_q30 + turn_q30) / Q30;
      if (v > WHEEL_MAX) begin
        v = WHEEL_MAX;
      end
      if (v < -WHEEL_MAX) begin
        v = -WHEEL_MAX;
      end
      return v;
    endfunction

    // Works out the wheel word for an accepted command and queues it.
    function void note_command(logic [11:0] angle, logic [9:0] spd, logic signed [10:0] trn);
      int          idx;
      int          cidx;
      longint      sx;
      longint      cy;
      longint      plus;
      longint      minus;
      longint      turn_q30;
      longint      lim;
      longint      mag;
      longint      w [4];
      wheel_word_t e;
      idx  = (int'(angle[9:0]) * TAB_DEPTH) / 1024;
      cidx = TAB_DEPTH - idx;
      case (angle[11:10])
        2'd0: begin
          sx = sine_tab[idx];
          cy = sine_tab[cidx];
        end
        2'd1: begin
          sx = sine_tab[cidx];
          cy = -sine_tab[idx];
        end
        2'd2: begin
          sx = -sine_tab[idx];
          cy = -sine_tab[cidx];
        end
        default: begin
          sx = -sine_tab[cidx];
          cy = sine_tab[idx];
        end
      endcase
      plus     = longint'(spd) * longint'(omw_pkg::MIX_K_Q16) * (sx + cy);
      minus    = longint'(spd) * longint'(omw_pkg::MIX_K_Q16) * (cy - sx);
      turn_q30 = longint'(trn) * longint'(turn_gain) * (64'sd1 <<< 22);
      // Wheel layout of the X frame: diagonal pairs share the translational term.
      w[0] = wheel_speed(plus, turn_q30);
      w[1] = wheel_speed(minus, -turn_q30);
      w[2] = wheel_speed(minus, turn_q30);
      w[3] = wheel_speed(plus, -turn_q30);
      lim = longint'(pwm_limit);
      if (lim > (64'sd1 <<< omw_pkg::DUTY_BITS_DEF) - 1) begin
        lim = (64'sd1 <<< omw_pkg::DUTY_BITS_DEF) - 1;
      end
      for (int k = 0; k < 4; k++) begin
        mag = (w[k] < 0) ? -w[k] : w[k];
        if (mag > lim) begin
          mag = lim;
        end
        e.wspeed[k] = 13'(w[k]);
        e.fwd[k]    = (w[k] > 0) ^ invert_polarity;
        e.duty[k]   = 10'(mag);
      end
      pending_wheels.push_back(e);
    endfunction

    // Compares a delivered wheel word with the oldest expectation.
    function void check_wheels(wheel_word_t got);
      wheel_word_t e;
      if (pending_wheels.size() == 0) begin
        $error("wheel word arrived with no command outstanding");
        mismatches++;
        return;
      end
      e = pending_wheels.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got.wspeed[k] !== e.wspeed[k]) begin
          $error("%s_speed expected %0d got %0d", wheel_name[k], e.wspeed[k], got.wspeed[k]);
          mismatches++;
        end
        if (got.fwd[k] !== e.fwd[k]) begin
          $error("%s_forward expected %0d got %0d", wheel_name[k], e.fwd[k], got.fwd[k]);
          mismatches++;
        end
        if (got.duty[k] !== e.duty[k]) begin
          $error("%s_duty expected %0d got %0d", wheel_name[k], e.duty[k], got.duty[k]);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return pending_wheels.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_omni_wheel_mixer.sv =====
// Top-level testbench of the omni wheel mixer: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps

module tb_omni_wheel_mixer;

  localparam int         HOLD_CYCLES  = 80;
  localparam int         SETTLE       = 8;
  localparam int         RAND_PHASES  = 6;
  localparam int         PHASE_WORDS  = 300;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [omw_pkg::PADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [11:0]        direction_angle = '0;
  logic [9:0]         speed           = '0;
  logic signed [10:0] turn            = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [12:0] front_left_speed, front_right_speed, back_left_speed, back_right_speed;
  logic               front_left_forward, front_right_forward;
  logic               back_left_forward, back_right_forward;
  logic [9:0]         front_left_duty, front_right_duty, back_left_duty, back_right_duty;

  // Flags shared by the sender and the receiver processes.
  bit calm     = 1'b0;
  bit hold_out = 1'b0;

  omw_mix_check_pkg::wheel_mix_checker mix_chk = new();

  omni_wheel_mixer u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .direction_angle     (direction_angle),
    .speed               (speed),
    .turn                (turn),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .front_left_speed    (front_left_speed),
    .front_right_speed   (front_right_speed),
    .back_left_speed     (back_left_speed),
    .back_right_speed    (back_right_speed),
    .front_left_forward  (front_left_forward),
    .front_right_forward (front_right_forward),
    .back_left_forward   (back_left_forward),
    .back_right_forward  (back_right_forward),
    .front_left_duty     (front_left_duty),
    .front_right_duty    (front_right_duty),
    .back_left_duty      (back_left_duty),
    .back_right_duty     (back_right_duty)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Register write: a setup phase, an access phase, then an idle bus.
  task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= omw_pkg::PADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mix_chk.write_reg(index, value);
    @(posedge clk);
  endtask

  // Writes all three registers with junk in the unused upper bits, plus a stray write.
  task automatic apply_config(input logic [9:0] lim, input logic [11:0] gain, input logic inv);
    reg_write(omw_pkg::REG_PWM_LIMIT, ($urandom() & ~32'h3FF) | 32'(lim));
    reg_write(omw_pkg::REG_TURN_GAIN, ($urandom() & ~32'hFFF) | 32'(gain));
    reg_write(omw_pkg::REG_INVERT, ($urandom() & ~32'h1) | 32'(inv));
    reg_write(REG_UNMAPPED, $urandom());
  endtask

  // Offers one command word and waits until the block takes it.
  task automatic send_word(input logic [11:0] a, input logic [9:0] s,
                           input logic signed [10:0] t, input bit gaps);
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    direction_angle <= a;
    speed           <= s;
    turn            <= t;
    do @(posedge clk); while (in_stall);
    mix_chk.note_command(a, s, t);
  endtask

  // Stops offering words until every expected wheel word has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (mix_chk.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random command word, biased toward quadrant edges and field extremes.
  task automatic random_word(output logic [11:0] a, output logic [9:0] s,
                             output logic signed [10:0] t);
    if ($urandom_range(0, 7) == 0) begin
      a = 12'($urandom_range(0, 3) * 1024 + ($urandom_range(0, 1) ? 1023 : 0));
    end else begin
      a = 12'($urandom());
    end
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = 10'd1023;
      default: s = 10'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       t = -11'sd1024;
      1:       t = 11'sd1023;
      2:       t = '0;
      default: t = 11'($urandom());
    endcase
  endtask

  // Receiver: random stall bursts, one long hold on request, none once calm.
  initial begin
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Every word handed over on the output channel is checked.
  always @(posedge clk) begin : out_monitor
    omw_mix_check_pkg::wheel_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.wspeed = '{front_left_speed, front_right_speed, back_left_speed, back_right_speed};
      got.fwd    = '{front_left_forward, front_right_forward,
                     back_left_forward, back_right_forward};
      got.duty   = '{front_left_duty, front_right_duty, back_left_duty, back_right_duty};
      mix_chk.check_wheels(got);
    end
  end

  initial begin
    #10_000_000;
    $display("tb_omni_wheel_mixer: errors");
    $finish;
  end

  initial begin : stimulus
    logic [11:0]        a;
    logic [9:0]         s;
    logic signed [10:0] t;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: zero speed, axes, diagonals, turn extremes.
    send_word(12'd0,    10'd0,    11'sd0,     1'b1);
    send_word(12'd0,    10'd1023, 11'sd0,     1'b1);
    send_word(12'd1024, 10'd1023, 11'sd0,     1'b1);
    send_word(12'd2048, 10'd1023, 11'sd0,     1'b1);
    send_word(12'd3072, 10'd1023, 11'sd0,     1'b1);
    send_word(12'd4095, 10'd1023, 11'sd0,     1'b1);
    send_word(12'd512,  10'd1023, 11'sd0,     1'b1);
    send_word(12'd1536, 10'd700,  -11'sd300,  1'b1);
    send_word(12'd0,    10'd0,    11'sd1023,  1'b1);
    send_word(12'd0,    10'd0,    -11'sd1024, 1'b1);
    send_word(12'd2560, 10'd1023, -11'sd1024, 1'b1);
    send_word(12'd3584, 10'd1023, 11'sd1023,  1'b1);
    send_word(12'd1,    10'd1,    -11'sd1,    1'b1);
    send_word(12'd1023, 10'd512,  11'sd5,     1'b1);
    drain_results();

    // Maximum gain drives the wheels into saturation; forward bits inverted.
    apply_config(10'd1023, 12'd4095, 1'b1);
    send_word(12'd512,  10'd1023, 11'sd1023,  1'b1);
    send_word(12'd2560, 10'd1023, -11'sd1024, 1'b1);
    send_word(12'd0,    10'd0,    11'sd0,     1'b1);
    send_word(12'd0,    10'd1023, -11'sd1024, 1'b1);
    send_word(12'd1536, 10'd1023, 11'sd1023,  1'b1);
    send_word(12'd3584, 10'd0,    -11'sd1,    1'b1);
    send_word(12'd0,    10'd0,    11'sd1,     1'b1);

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       apply_config(10'd1023, 12'd4095, 1'b0);
        1:       apply_config(10'd0, 12'd0, 1'b1);
        default: apply_config(10'($urandom()), 12'($urandom()), 1'($urandom()));
      endcase
      if (ph == RAND_PHASES - 1) begin
        calm = 1'b1;
      end
      if (ph == 2) begin
        hold_out = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 3 && n == PHASE_WORDS / 2) begin
          drain_results();
        end
        random_word(a, s, t);
        // Keep the input busy while the receiver holds off so the pipeline fills.
        send_word(a, s, t, !(ph == 2 && n < 40));
      end
    end

    in_valid <= 1'b0;
    while (mix_chk.outstanding() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (mix_chk.mismatches == 0 && mix_chk.outstanding() == 0) begin
      $display("tb_omni_wheel_mixer: clean");
    end else begin
      $display("tb_omni_wheel_mixer: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/omw_pkg.sv
rtl/core/omw_ram.sv
rtl/core/omw_regs.sv
rtl/core/omni_wheel_mixer.sv
rtl/core/omw_checker.sv
tb/omw_mix_check_pkg.sv
tb/tb_omni_wheel_mixer.sv
